@@ hw/rtl/wled_pkg.sv @@
package wled_pkg;

    localparam int MAX_COLS    = 1024;
    localparam int MAX_ROWS    = 1024;
    localparam int HEIGHT_BITS = 16;

    localparam int COL_BITS    = $clog2(MAX_COLS);
    localparam int ROW_BITS    = $clog2(MAX_ROWS);
    localparam int CFG_BITS    = 11;
    localparam int CFG_IDX_BITS = 1;
    localparam int COUNT_BITS  = 20;
    localparam int WIN_TAPS    = 9;
    localparam int CENTER_TAP  = 4;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_ROWS = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_COLS = 1'b1;

    typedef logic signed [HEIGHT_BITS-1:0] height_t;

    typedef enum logic [1:0] {
        CLASS_NONE   = 2'd0,
        CLASS_PEAK   = 2'd1,
        CLASS_VALLEY = 2'd2
    } point_class_t;

    typedef struct packed {
        logic peak;
        logic valley;
    } class_flags_t;

    // packed result, first field in the high bits, center_row in the low bits
    typedef struct packed {
        logic [COUNT_BITS-1:0] valley_total;
        logic [COUNT_BITS-1:0] peak_total;
        point_class_t          point_class;
        logic [COL_BITS-1:0]   center_col;
        logic [ROW_BITS-1:0]   center_row;
    } result_t;

    localparam int RESULT_BITS = $bits(result_t);
    localparam int OUT_BYTES   = (RESULT_BITS + 7) / 8;
    localparam int OUT_BITS    = OUT_BYTES * 8;
    localparam int IN_BITS     = ((HEIGHT_BITS + 7) / 8) * 8;

    // last index (dimension - 1) after clamping the raw value to 3..max_dim
    function automatic logic [CFG_BITS+1:0] dim_last(input logic [CFG_BITS-1:0] v,
                                                      input logic [CFG_BITS+1:0] max_dim);
        logic [CFG_BITS+1:0] ext;
        ext = {2'b00, v};
        if (ext < 13'd3)
            dim_last = 13'd2;
        else if (ext > max_dim)
            dim_last = max_dim - 13'd1;
        else
            dim_last = ext - 13'd1;
    endfunction

endpackage

@@ hw/rtl/wled_line_store.sv @@
module wled_line_store (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [wled_pkg::COL_BITS-1:0] wr_addr,
    input  wled_pkg::height_t        wr_data,
    input  logic [wled_pkg::COL_BITS-1:0] rd_addr,
    output wled_pkg::height_t        rd_data
);
    import wled_pkg::*;

    height_t mem [MAX_COLS];
    height_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/wled_classify.sv @@
module wled_classify (
    input  wled_pkg::height_t      win [wled_pkg::WIN_TAPS],
    output wled_pkg::class_flags_t flags
);
    import wled_pkg::*;

    always_comb
    begin
        flags.peak   = 1'b1;
        flags.valley = 1'b1;
        for (int k = 0; k < WIN_TAPS; k++)
        begin
            if (win[k] > win[CENTER_TAP])
                flags.peak = 1'b0;
            if (win[k] < win[CENTER_TAP])
                flags.valley = 1'b0;
        end
    end

endmodule

@@ hw/rtl/window_local_extrema_detector_core.sv @@
// A result appears in m_tvalid in the cycle after its input item is accepted.
// Throughput: one item per cycle; s_tready drops only while a result waits on m_tready.
// Border samples produce no result; interior samples produce exactly one.
// Reset: positions, counters, window and output valid clear; frame is 3x3.
// Line stores are not cleared: rows 0 and 1 of each frame fill them before use.
module window_local_extrema_detector_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // input item stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [wled_pkg::IN_BITS-1:0]      s_tdata,   // [15:0] height (signed)
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [9:0] center_row, [19:10] center_col, [21:20] point_class,
    // [41:22] peak_total, [61:42] valley_total, [63:62] zero
    output logic [wled_pkg::OUT_BITS-1:0]     m_tdata,
    output logic                              m_tlast,   // frame_end
    // configuration writes
    input  logic                              cfg_we,
    input  logic [wled_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [wled_pkg::CFG_BITS-1:0]     cfg_data
);
    import wled_pkg::*;

    localparam logic [CFG_BITS+1:0] MAX_ROWS_W = (CFG_BITS+2)'(MAX_ROWS);
    localparam logic [CFG_BITS+1:0] MAX_COLS_W = (CFG_BITS+2)'(MAX_COLS);

    // frame geometry, kept as last index after clamping
    logic [ROW_BITS-1:0]   last_row_reg, last_row_next;
    logic [COL_BITS-1:0]   last_col_reg, last_col_next;

    // raster position of the incoming sample
    logic [ROW_BITS-1:0]   row_reg, row_next;
    logic [COL_BITS-1:0]   col_reg, col_next;

    logic [COUNT_BITS-1:0] peak_cnt_reg, peak_cnt_next;
    logic [COUNT_BITS-1:0] valley_cnt_reg, valley_cnt_next;

    // window columns: [0..2] two samples back, [3..5] one sample back (upper, middle, lower)
    height_t               win_reg [6];
    height_t               win_next [6];

    logic                  out_valid_reg, out_valid_next;
    logic                  out_last_reg, out_last_next;
    result_t               out_data_reg, out_data_next;

    logic                  accept;
    logic                  emit;
    logic                  row_end;
    logic                  frame_last;
    height_t               h;
    height_t               up_rd;
    height_t               md_rd;
    height_t               taps [WIN_TAPS];
    class_flags_t          flags;
    logic [COUNT_BITS-1:0] peak_total;
    logic [COUNT_BITS-1:0] valley_total;
    point_class_t          cls;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign h        = height_t'(s_tdata[HEIGHT_BITS-1:0]);

    assign row_end    = (col_reg == last_col_reg);
    assign frame_last = row_end && (row_reg == last_row_reg);
    assign emit       = (row_reg >= ROW_BITS'(2)) && (col_reg >= COL_BITS'(2));

    // Line stores are prefetched at the next column so read data is ready when the
    // item at that column arrives. Writes go to the current column, which never
    // matches the prefetch address on an accept since a row has at least 3 columns.
    wled_line_store u_upper (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (md_rd),
        .rd_addr (col_next),
        .rd_data (up_rd)
    );

    wled_line_store u_middle (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (h),
        .rd_addr (col_next),
        .rd_data (md_rd)
    );

    always_comb
    begin
        for (int k = 0; k < 6; k++)
            taps[k] = win_reg[k];
        taps[6] = up_rd;
        taps[7] = md_rd;
        taps[8] = h;
    end

    wled_classify u_classify (
        .win   (taps),
        .flags (flags)
    );

    // running totals including this centre
    assign peak_total   = (flags.peak && peak_cnt_reg != COUNT_MAX)
                          ? peak_cnt_reg + COUNT_BITS'(1) : peak_cnt_reg;
    assign valley_total = (flags.valley && valley_cnt_reg != COUNT_MAX)
                          ? valley_cnt_reg + COUNT_BITS'(1) : valley_cnt_reg;

    always_comb
    begin
        if (flags.valley)
            cls = CLASS_VALLEY;   // plateau reads as valley
        else if (flags.peak)
            cls = CLASS_PEAK;
        else
            cls = CLASS_NONE;
    end

    always_comb
    begin
        last_row_next   = last_row_reg;
        last_col_next   = last_col_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        peak_cnt_next   = peak_cnt_reg;
        valley_cnt_next = valley_cnt_reg;
        win_next        = win_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_last_next   = out_last_reg;
        out_data_next   = out_data_reg;

        if (cfg_we)
        begin
            // any register write restarts the frame
            case (cfg_index)
                REG_FRAME_ROWS: last_row_next = ROW_BITS'(dim_last(cfg_data, MAX_ROWS_W));
                REG_FRAME_COLS: last_col_next = COL_BITS'(dim_last(cfg_data, MAX_COLS_W));
                default:        last_row_next = last_row_reg;
            endcase
            row_next        = '0;
            col_next        = '0;
            peak_cnt_next   = '0;
            valley_cnt_next = '0;
            for (int k = 0; k < 6; k++)
                win_next[k] = '0;
        end
        else if (accept)
        begin
            if (emit)
            begin
                peak_cnt_next              = peak_total;
                valley_cnt_next            = valley_total;
                out_valid_next             = 1'b1;
                out_last_next              = frame_last;
                out_data_next.center_row   = row_reg - ROW_BITS'(1);
                out_data_next.center_col   = col_reg - COL_BITS'(1);
                out_data_next.point_class  = cls;
                out_data_next.peak_total   = peak_total;
                out_data_next.valley_total = valley_total;
            end

            win_next[0] = win_reg[3];
            win_next[1] = win_reg[4];
            win_next[2] = win_reg[5];
            win_next[3] = up_rd;
            win_next[4] = md_rd;
            win_next[5] = h;

            if (row_end)
            begin
                col_next = '0;
                if (frame_last)
                begin
                    row_next        = '0;
                    peak_cnt_next   = '0;
                    valley_cnt_next = '0;
                end
                else
                begin
                    row_next = row_reg + ROW_BITS'(1);
                end
            end
            else
            begin
                col_next = col_reg + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_row_reg   <= ROW_BITS'(2);
            last_col_reg   <= COL_BITS'(2);
            row_reg        <= '0;
            col_reg        <= '0;
            peak_cnt_reg   <= '0;
            valley_cnt_reg <= '0;
            out_valid_reg  <= 1'b0;
            for (int k = 0; k < 6; k++)
                win_reg[k] <= '0;
        end
        else
        begin
            last_row_reg   <= last_row_next;
            last_col_reg   <= last_col_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            peak_cnt_reg   <= peak_cnt_next;
            valley_cnt_reg <= valley_cnt_next;
            out_valid_reg  <= out_valid_next;
            win_reg        <= win_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_last_reg <= out_last_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(OUT_BITS-RESULT_BITS){1'b0}}, out_data_reg};

endmodule

@@ hw/rtl/wled_checker.sv @@
module wled_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [wled_pkg::OUT_BITS-1:0]     m_tdata,
    input logic                              m_tlast
);
    import wled_pkg::*;

    result_t res;
    assign res = result_t'(m_tdata[RESULT_BITS-1:0]);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // an empty output stage always takes input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // centres are interior and the class code is legal
    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> res.center_row != '0 && res.center_col != '0
                     && res.point_class != point_class_t'(2'd3))
        else $error("bad centre position or class");

    // a classified extremum is included in its own total
    a_totals: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res.point_class != CLASS_PEAK || res.peak_total != '0)
                  && (res.point_class != CLASS_VALLEY || res.valley_total != '0))
        else $error("total does not include current extremum");

endmodule

bind window_local_extrema_detector_core wled_checker u_wled_checker (.*);

@@ sim/window_local_extrema_detector_core_tb.sv @@
`timescale 1ns / 100ps

// Checks the 3x3 local extrema detector against an in-bench window classifier.
// Every accepted sample runs through the classifier; interior centers queue an
// expected result, which is matched field by field against m_tdata / m_tlast.
module window_local_extrema_detector_core_tb;

    import wled_pkg::*;

    localparam int STALL_LIMIT = 2000;   // cycles with no traffic at all
    localparam int LONG_HOLD   = 300;    // receiver hold-off for the fill-up test

    // one expected result item
    typedef struct {
        result_t res;
        logic    frame_end;
    } extremum_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_BITS-1:0]      s_tdata;     // [15:0] height (signed)
    logic                    m_tvalid;
    logic                    m_tready;
    // [9:0] center_row, [19:10] center_col, [21:20] point_class,
    // [41:22] peak_total, [61:42] valley_total, [63:62] zero
    logic [OUT_BITS-1:0]     m_tdata;
    logic                    m_tlast;     // frame_end
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]     cfg_data;

    window_local_extrema_detector_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------- classifier state ----------------
    logic [CFG_BITS-1:0]   cfg_rows;
    logic [CFG_BITS-1:0]   cfg_cols;
    height_t               row_above[MAX_COLS];   // two rows up
    height_t               row_prev[MAX_COLS];    // one row up
    height_t               win[6];
    int unsigned           row_pos;
    int unsigned           col_pos;
    logic [COUNT_BITS-1:0] peak_cnt;
    logic [COUNT_BITS-1:0] valley_cnt;

    extremum_t             pending_extrema[$];

    // run control and bookkeeping
    int unsigned send_gap_max = 0;
    int unsigned recv_gap_max = 0;
    int unsigned hold_cycles  = 0;
    int unsigned fail_count   = 0;
    int unsigned n_items      = 0;
    int unsigned n_results    = 0;
    int unsigned n_settings   = 0;
    int unsigned n_peak       = 0;
    int unsigned n_valley     = 0;
    int unsigned n_neither    = 0;

    function automatic int unsigned clamp_dim(input logic [CFG_BITS-1:0] raw,
                                              input int unsigned hi);
        if (raw < 3)
            return 3;
        if (raw > hi)
            return hi;
        return raw;
    endfunction

    function automatic void restart_frame();
        foreach (win[k])
            win[k] = '0;
        row_pos    = 0;
        col_pos    = 0;
        peak_cnt   = '0;
        valley_cnt = '0;
    endfunction

    // Advances the window by one sample; returns 1 when an interior center was
    // classified, with the expected result in 'e'.
    function automatic bit classify_center(input height_t h, output extremum_t e);
        int unsigned rows;
        int unsigned cols;
        int unsigned ci;
        height_t     up;
        height_t     md;
        height_t     ctr;
        height_t     taps[9];
        bit          is_peak;
        bit          is_trough;
        bit          hit;
        rows = clamp_dim(cfg_rows, MAX_ROWS);
        cols = clamp_dim(cfg_cols, MAX_COLS);
        ci   = (col_pos < MAX_COLS) ? col_pos : MAX_COLS - 1;
        up   = row_above[ci];
        md   = row_prev[ci];
        hit  = 1'b0;
        e    = '{default: '0};

        if (row_pos >= 2 && col_pos >= 2)
        begin
            taps      = '{win[0], win[1], win[2], win[3], win[4], win[5], up, md, h};
            ctr       = win[4];
            is_peak   = 1'b1;
            is_trough = 1'b1;
            foreach (taps[k])
            begin
                if (taps[k] > ctr)
                    is_peak = 1'b0;
                if (taps[k] < ctr)
                    is_trough = 1'b0;
            end
            // a plateau counts in both totals but reads as a valley
            if (is_peak && peak_cnt != COUNT_MAX)
                peak_cnt++;
            if (is_trough && valley_cnt != COUNT_MAX)
                valley_cnt++;
            e.res.center_row   = ROW_BITS'(row_pos - 1);
            e.res.center_col   = COL_BITS'(col_pos - 1);
            e.res.point_class  = is_trough ? CLASS_VALLEY : (is_peak ? CLASS_PEAK : CLASS_NONE);
            e.res.peak_total   = peak_cnt;
            e.res.valley_total = valley_cnt;
            e.frame_end        = (row_pos + 1 >= rows) && (col_pos + 1 >= cols);
            hit = 1'b1;
        end

        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = up;
        win[4] = md;
        win[5] = h;
        row_above[ci] = md;
        row_prev[ci]  = h;

        if (col_pos + 1 >= cols)
        begin
            col_pos = 0;
            if (row_pos + 1 >= rows)
            begin
                // frame done: totals restart with the next sample
                row_pos    = 0;
                peak_cnt   = '0;
                valley_cnt = '0;
            end
            else
                row_pos = row_pos + 1;
        end
        else
            col_pos = col_pos + 1;
        return hit;
    endfunction

    // ---------------- stimulus helpers ----------------
    // Mostly a narrow band so ties and plateaus are common, plus full-range
    // values and the signed corners.
    function automatic height_t random_height();
        case ($urandom_range(3, 0))
            0: return height_t'($urandom);
            1:
            begin
                case ($urandom_range(3, 0))
                    0: return height_t'(-32768);
                    1: return height_t'(32767);
                    2: return height_t'(-1);
                    default: return height_t'(0);
                endcase
            end
            default: return height_t'(int'($urandom_range(4, 0)) - 2);
        endcase
    endfunction

    function automatic int unsigned pick_gap_limit();
        case ($urandom_range(2, 0))
            0: return 0;
            1: return 3;
            default: return 16;
        endcase
    endfunction

    task automatic send_height(input height_t h);
        int unsigned gap;
        extremum_t   e;
        gap = $urandom_range(send_gap_max, 0);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= h;
        do
            @(posedge clk);
        while (!s_tready);
        if (classify_center(h, e))
            pending_extrema.push_back(e);
        n_items++;
    endtask

    // Stop sending and let every expected result drain, plus the pipeline depth
    // for border samples still in flight.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_extrema.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Any accepted write restarts the frame.
    task automatic set_frame(input logic [CFG_BITS-1:0] rows_raw,
                             input logic [CFG_BITS-1:0] cols_raw,
                             input bit write_rows, input bit write_cols);
        wait_idle();
        if (write_rows)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_FRAME_ROWS;
            cfg_data  <= rows_raw;
            @(posedge clk);
            cfg_rows = rows_raw;
            restart_frame();
        end
        if (write_cols)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_FRAME_COLS;
            cfg_data  <= cols_raw;
            @(posedge clk);
            cfg_cols = cols_raw;
            restart_frame();
        end
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // ---------------- tests ----------------
    // Reset frame size (3x3): a peak tied with a neighbor, a flat plateau, and a
    // ramp that is neither. Also checks totals clear at each frame end.
    task automatic test_directed_extrema();
        height_t peak_frame[9]    = '{-32768, 0, 32767, -1, 32767, 100, 32766, -32768, 5};
        height_t plateau_frame[9] = '{-7, -7, -7, -7, -7, -7, -7, -7, -7};
        height_t ramp_frame[9]    = '{0, 1, 2, 3, 4, 5, 6, 7, 8};
        send_gap_max = 0;
        recv_gap_max = 0;
        foreach (peak_frame[k])
            send_height(peak_frame[k]);
        foreach (plateau_frame[k])
            send_height(plateau_frame[k]);
        foreach (ramp_frame[k])
            send_height(ramp_frame[k]);
    endtask

    // A write mid-frame throws away the partial frame; single-register writes
    // keep the other dimension.
    task automatic test_frame_restart();
        send_gap_max = 16;
        recv_gap_max = 16;
        set_frame(11'd5, 11'd4, 1'b1, 1'b1);
        repeat (11) send_height(random_height());
        set_frame(11'd0, 11'd6, 1'b0, 1'b1);
        repeat (30) send_height(random_height());
        set_frame(11'd4, 11'd0, 1'b1, 1'b0);
        repeat (48) send_height(random_height());
    endtask

    // Receiver stops for a long stretch while samples keep coming, so the
    // output register fills and s_tready has to drop.
    task automatic test_output_backpressure();
        set_frame(11'd4, 11'd4, 1'b1, 1'b1);
        send_gap_max = 0;
        recv_gap_max = 0;
        hold_cycles  = LONG_HOLD;
        repeat (48) send_height(random_height());
        wait_idle();
        recv_gap_max = 16;
    endtask

    // Widest and tallest settings, reached through exact and out-of-range
    // values; the frames are cut short to keep the run short.
    task automatic test_dimension_limits();
        send_gap_max = 2;
        recv_gap_max = 2;
        set_frame(11'd2, 11'd1024, 1'b1, 1'b1);      // 3 x 1024
        repeat (64) send_height(random_height());
        set_frame(11'd2047, 11'd0, 1'b1, 1'b1);      // 1024 x 3
        repeat (3 * 40) send_height(random_height());
    endtask

    // Small random frames back to back, sometimes cut short by the next write.
    task automatic test_random_frames();
        int unsigned         sent;
        int unsigned         frame_len;
        int unsigned         n_frames;
        int unsigned         partial;
        logic [CFG_BITS-1:0] rows_raw;
        logic [CFG_BITS-1:0] cols_raw;
        sent = 0;
        while (sent < 280)
        begin
            rows_raw = ($urandom_range(7, 0) == 0) ? CFG_BITS'($urandom_range(2, 0))
                                                   : CFG_BITS'($urandom_range(8, 3));
            cols_raw = ($urandom_range(7, 0) == 0) ? CFG_BITS'($urandom_range(2, 0))
                                                   : CFG_BITS'($urandom_range(12, 3));
            case ($urandom_range(3, 0))
                0: set_frame(rows_raw, cols_raw, 1'b1, 1'b0);
                1: set_frame(rows_raw, cols_raw, 1'b0, 1'b1);
                default: set_frame(rows_raw, cols_raw, 1'b1, 1'b1);
            endcase
            send_gap_max = pick_gap_limit();
            recv_gap_max = pick_gap_limit();
            frame_len = clamp_dim(cfg_rows, MAX_ROWS) * clamp_dim(cfg_cols, MAX_COLS);
            n_frames  = $urandom_range(3, 1);
            partial   = ($urandom_range(3, 0) == 0) ? $urandom_range(frame_len - 1, 1) : 0;
            repeat (n_frames * frame_len + partial)
            begin
                send_height(random_height());
                sent++;
            end
        end
    endtask

    // ---------------- receiver ----------------
    initial
    begin : result_sink
        int unsigned gap;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            gap = $urandom_range(recv_gap_max, 0);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // ---------------- result checker ----------------
    task automatic compare_field(input string name, input logic [COUNT_BITS-1:0] want,
                                 input logic [COUNT_BITS-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        result_t   got;
        extremum_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[RESULT_BITS-1:0]);
            if (pending_extrema.size() == 0)
            begin
                $error("unexpected result item: m_tdata %h m_tlast %b", m_tdata, m_tlast);
                fail_count++;
            end
            else
            begin
                want = pending_extrema.pop_front();
                n_results++;
                case (want.res.point_class)
                    CLASS_PEAK:   n_peak++;
                    CLASS_VALLEY: n_valley++;
                    default:      n_neither++;
                endcase
                compare_field("center_row", want.res.center_row, got.center_row);
                compare_field("center_col", want.res.center_col, got.center_col);
                compare_field("point_class", want.res.point_class, got.point_class);
                compare_field("peak_total", want.res.peak_total, got.peak_total);
                compare_field("valley_total", want.res.valley_total, got.valley_total);
                compare_field("frame_end", want.frame_end, m_tlast);
                compare_field("tdata_pad", '0, m_tdata[OUT_BITS-1:RESULT_BITS]);
            end
        end
    end

    // ---------------- watchdog ----------------
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending_extrema.size());
        $display("Simulation FAILED");
        $finish;
    end

    // ---------------- main sequence ----------------
    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_FRAME_ROWS;
        cfg_data  <= '0;
        cfg_rows   = 11'd3;
        cfg_cols   = 11'd3;
        restart_frame();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_extrema();
        test_frame_restart();
        test_output_backpressure();
        test_dimension_limits();
        test_random_frames();

        wait_idle();
        repeat (8) @(posedge clk);

        $display("Run covered %0d samples over %0d frame settings (3x3 up to 3x1024 and 1024x3).",
                 n_items, n_settings);
        $display("Checked %0d results: %0d peak, %0d valley or plateau, %0d neither.",
                 n_results, n_peak, n_valley, n_neither);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/wled_pkg.sv
hw/rtl/wled_line_store.sv
hw/rtl/wled_classify.sv
hw/rtl/window_local_extrema_detector_core.sv
hw/rtl/wled_checker.sv
sim/window_local_extrema_detector_core_tb.sv
